>>> sv/i2cm_pkg.sv
// Shared types and constants for the I2C register-access master.
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

  // Sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT,
    PH_START,
    PH_TX,
    PH_RESTART,
    PH_RX,
    PH_STOP
  } phase_e;

  // Item kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Register map
  localparam int unsigned PADDR_W = 3;
  localparam logic REG_SETUP = 1'b0;
  localparam logic REG_HALF  = 1'b1;

  localparam logic [7:0] SETUP_RST = 8'd5;
  localparam logic [7:0] HALF_RST  = 8'd25;
  localparam logic [7:0] HALF_MIN  = 8'd2;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [3:0] SUB_STEP_1    = 4'd1;
  localparam logic [3:0] SUB_STEP_2    = 4'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [7:0] write_value;
    logic [7:0] read_count;
    logic       sda_in;
    logic       scl_in;
  } i2cm_in_t;

  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic [7:0] rx_data;
    logic       rx_valid;
    logic       rx_final;
    logic       no_ack;
    logic       engine_busy;
    logic       transfer_done;
    logic       command_rejected;
  } i2cm_out_t;

  // Effective (clamped) bit timing
  typedef struct packed {
    logic [7:0] setup;
    logic [7:0] half;
  } i2cm_timing_t;

endpackage

`default_nettype wire

>>> sv/i2c_master_register_access_top.sv
// Top level of the I2C register-access master: input and result registers, APB, sequencer.
//
//   port     | dir | handshake              | word
//   ---------+-----+------------------------+----------------------------
//   in       | in  | in_valid_i / in_stall_o   | i2cm_in_t  (tick or command)
//   out      | out | out_valid_o / out_stall_i | i2cm_out_t (one per input)
//   apb      | in  | psel/penable/pwrite, pready=1 | setup, half period
//
// One word per clock sustained while the result side is not stalled: a word is
// held in the input register, the sequencer step runs between it and the
// result register, and out_valid_o rises when the result register loads it.
// A stalled result holds; the input register keeps taking a word while the
// result register is free or being drained this cycle.
// Reset clears the sequencer to idle with both lines released and loads
// setup 5 / half period 25. Writes pass the register, then the clamped timing register.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_register_access_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire i2cm_pkg::i2cm_in_t            in_word_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output i2cm_pkg::i2cm_out_t                out_word_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [i2cm_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);

  logic                   in_valid_q, in_valid_d;
  i2cm_pkg::i2cm_in_t     in_word_q;
  logic                   out_valid_q, out_valid_d;
  i2cm_pkg::i2cm_out_t    out_word_q;
  i2cm_pkg::i2cm_out_t    step_res;
  i2cm_pkg::i2cm_timing_t timing;
  logic                   fire, in_take;

  i2cm_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .timing_o (timing)
  );

  i2cm_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (fire),
    .word_i   (in_word_q),
    .timing_i (timing),
    .result_o (step_res)
  );

  // step when the result register is empty or drains this cycle
  assign fire       = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~fire;
  assign in_take    = in_valid_i & ~in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take)   in_valid_d = 1'b1;
    else if (fire) in_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (fire)              out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) in_word_q  <= in_word_i;
    if (fire)    out_word_q <= step_res;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

>>> sv/i2cm_regs.sv
// APB register file for the bit timing, with clamped effective values.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [i2cm_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready,
  output i2cm_pkg::i2cm_timing_t               timing_o
);

  logic [7:0] setup_q, setup_d;
  logic [7:0] half_q, half_d;
  logic [7:0] half_eff, setup_nz;
  logic       wr_en;
  i2cm_pkg::i2cm_timing_t timing_q, timing_d;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    setup_d = setup_q;
    half_d  = half_q;
    if (wr_en) begin
      case (paddr[2])
        i2cm_pkg::REG_SETUP: setup_d = pwdata[7:0];
        i2cm_pkg::REG_HALF:  half_d  = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      i2cm_pkg::REG_SETUP: prdata = {24'd0, setup_q};
      i2cm_pkg::REG_HALF:  prdata = {24'd0, half_q};
      default:             prdata = 32'd0;
    endcase
  end

  // half below 2 -> 2; setup 0 -> 1, setup >= half -> half - 1
  always_comb begin
    half_eff = (half_q < i2cm_pkg::HALF_MIN) ? i2cm_pkg::HALF_MIN : half_q;
    setup_nz = (setup_q == 8'd0) ? 8'd1 : setup_q;
    timing_d.half  = half_eff;
    timing_d.setup = (setup_nz >= half_eff) ? (half_eff - 8'd1) : setup_nz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_q        <= i2cm_pkg::SETUP_RST;
      half_q         <= i2cm_pkg::HALF_RST;
      timing_q.setup <= i2cm_pkg::SETUP_RST;
      timing_q.half  <= i2cm_pkg::HALF_RST;
    end else begin
      setup_q  <= setup_d;
      half_q   <= half_d;
      timing_q <= timing_d;
    end
  end

  assign timing_o = timing_q;

endmodule

`default_nettype wire

>>> sv/i2cm_engine.sv
// Bit-level I2C sequencer: state registers and the one-word step logic.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_engine (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   step_i,
  input  wire i2cm_pkg::i2cm_in_t     word_i,
  input  wire i2cm_pkg::i2cm_timing_t timing_i,
  output i2cm_pkg::i2cm_out_t         result_o
);

  typedef struct packed {
    i2cm_pkg::phase_e phase;
    logic [7:0]       tick;
    logic [3:0]       bitpos;
    logic [7:0]       bytes_done;
    logic [7:0]       shift;
    logic [6:0]       held_dev;
    logic [7:0]       held_reg;
    logic [7:0]       held_value;
    logic [7:0]       held_count;
    logic             is_read;
    logic             scl_low;
    logic             sda_low;
  } eng_state_t;

  eng_state_t st_q, st_d;
  logic [8:0] tc_inc;
  logic       inc_ge_s, inc_ge_h, last_rx, bit_lt8;
  logic [7:0] rx_shift;

  function automatic eng_state_t begin_byte(eng_state_t s, logic [1:0] idx);
    eng_state_t r;
    logic [7:0] addr_byte;
    r = s;
    addr_byte = {s.held_dev, 1'b0};
    r.bytes_done = {6'd0, idx};
    case (idx)
      2'd0:    r.shift = addr_byte;
      2'd1:    r.shift = s.held_reg;
      default: r.shift = s.is_read ? {s.held_dev, 1'b1} : s.held_value;
    endcase
    r.bitpos = '0;
    r.tick   = '0;
    r.phase  = i2cm_pkg::PH_TX;
    return r;
  endfunction

  function automatic eng_state_t enter_stop(eng_state_t s);
    eng_state_t r;
    r = s;
    r.phase  = i2cm_pkg::PH_STOP;
    r.bitpos = '0;
    r.tick   = '0;
    return r;
  endfunction

  always_comb begin
    tc_inc   = {1'b0, st_q.tick} + 9'd1;
    inc_ge_s = tc_inc >= {1'b0, timing_i.setup};
    inc_ge_h = tc_inc >= {1'b0, timing_i.half};
    last_rx  = ({1'b0, st_q.bytes_done} + 9'd1) >= {1'b0, st_q.held_count};
    bit_lt8  = st_q.bitpos < i2cm_pkg::BITS_PER_BYTE;
    rx_shift = {st_q.shift[6:0], word_i.sda_in};
  end

  always_comb begin
    st_d     = st_q;
    result_o = '0;
    case (word_i.kind)
      i2cm_pkg::KIND_WRITE, i2cm_pkg::KIND_READ: begin
        if (st_q.phase != i2cm_pkg::PH_IDLE) begin
          result_o.command_rejected = 1'b1;
        end else begin
          st_d.held_dev   = word_i.device_address;
          st_d.held_reg   = word_i.register_address;
          st_d.held_value = word_i.write_value;
          st_d.held_count = (word_i.read_count == 8'd0) ? 8'd1 : word_i.read_count;
          st_d.is_read    = (word_i.kind == i2cm_pkg::KIND_READ);
          st_d.tick       = '0;
          st_d.bitpos     = '0;
          st_d.bytes_done = '0;
          st_d.phase      = i2cm_pkg::PH_WAIT;
        end
      end
      i2cm_pkg::KIND_TICK: begin
        case (st_q.phase)
          i2cm_pkg::PH_WAIT: begin
            // bus idle: both lines high
            if (word_i.sda_in && word_i.scl_in) begin
              st_d.phase   = i2cm_pkg::PH_START;
              st_d.sda_low = 1'b1;
              st_d.scl_low = 1'b0;
              st_d.tick    = '0;
            end
          end
          i2cm_pkg::PH_START: begin
            st_d.tick = tc_inc[7:0];
            if (inc_ge_s) begin
              st_d.scl_low = 1'b1;
              st_d = begin_byte(st_d, 2'd0);
            end
          end
          i2cm_pkg::PH_TX, i2cm_pkg::PH_RX: begin
            st_d.tick = tc_inc[7:0];
            if (st_q.scl_low) begin
              if (inc_ge_s) begin
                if (st_q.phase == i2cm_pkg::PH_TX) begin
                  st_d.sda_low = bit_lt8 ? ~st_q.shift[7] : 1'b0;
                end else begin
                  st_d.sda_low = bit_lt8 ? 1'b0 : ~last_rx;
                end
              end
              if (inc_ge_h) begin
                st_d.scl_low = 1'b0;
                st_d.tick    = '0;
              end
            end else if (inc_ge_h) begin
              // end of SCL high: sample SDA
              st_d.scl_low = 1'b1;
              st_d.tick    = '0;
              if (st_q.phase == i2cm_pkg::PH_TX) begin
                if (bit_lt8) begin
                  st_d.shift  = {st_q.shift[6:0], 1'b0};
                  st_d.bitpos = st_q.bitpos + 4'd1;
                end else begin
                  result_o.no_ack = word_i.sda_in;
                  if (st_q.bytes_done == 8'd0) begin
                    st_d = begin_byte(st_d, 2'd1);
                  end else if (st_q.bytes_done == 8'd1) begin
                    if (st_q.is_read) begin
                      st_d.phase  = i2cm_pkg::PH_RESTART;
                      st_d.bitpos = '0;
                    end else begin
                      st_d = begin_byte(st_d, 2'd2);
                    end
                  end else if (st_q.is_read) begin
                    st_d.phase      = i2cm_pkg::PH_RX;
                    st_d.bytes_done = '0;
                    st_d.bitpos     = '0;
                    st_d.shift      = '0;
                  end else begin
                    st_d = enter_stop(st_d);
                  end
                end
              end else begin
                if (bit_lt8) begin
                  st_d.shift  = rx_shift;
                  st_d.bitpos = st_q.bitpos + 4'd1;
                  if (st_q.bitpos == i2cm_pkg::BITS_PER_BYTE - 4'd1) begin
                    result_o.rx_valid = 1'b1;
                    result_o.rx_data  = rx_shift;
                    result_o.rx_final = last_rx;
                  end
                end else if (last_rx) begin
                  st_d = enter_stop(st_d);
                end else begin
                  st_d.bytes_done = st_q.bytes_done + 8'd1;
                  st_d.bitpos     = '0;
                  st_d.shift      = '0;
                end
              end
            end
          end
          i2cm_pkg::PH_RESTART: begin
            st_d.tick = tc_inc[7:0];
            if (st_q.bitpos == 4'd0) begin
              st_d.sda_low = 1'b0;
              if (inc_ge_h) begin
                st_d.scl_low = 1'b0;
                st_d.tick    = '0;
                st_d.bitpos  = i2cm_pkg::SUB_STEP_1;
              end
            end else if (st_q.bitpos == i2cm_pkg::SUB_STEP_1) begin
              if (inc_ge_s) begin
                st_d.sda_low = 1'b1;
                st_d.tick    = '0;
                st_d.bitpos  = i2cm_pkg::SUB_STEP_2;
              end
            end else if (inc_ge_s) begin
              st_d.scl_low = 1'b1;
              st_d = begin_byte(st_d, 2'd2);
            end
          end
          i2cm_pkg::PH_STOP: begin
            st_d.tick = tc_inc[7:0];
            if (st_q.bitpos == 4'd0) begin
              if (inc_ge_s) st_d.sda_low = 1'b1;
              if (inc_ge_h) begin
                st_d.scl_low = 1'b0;
                st_d.tick    = '0;
                st_d.bitpos  = i2cm_pkg::SUB_STEP_1;
              end
            end else if (inc_ge_s) begin
              st_d.sda_low           = 1'b0;
              result_o.transfer_done = 1'b1;
              st_d.phase             = i2cm_pkg::PH_IDLE;
              st_d.tick              = '0;
              st_d.bitpos            = '0;
              st_d.bytes_done        = '0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    result_o.scl_pull_low = st_d.scl_low;
    result_o.sda_pull_low = st_d.sda_low;
    result_o.engine_busy  = (st_d.phase != i2cm_pkg::PH_IDLE);
  end

  // all-zero state is idle with both lines released
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/i2cm_checker.sv
// Port-level assertions for the I2C register-access master, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire i2cm_pkg::i2cm_out_t out_word_o
);

  // a held result is not dropped
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_final_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.rx_final |-> out_word_o.rx_valid)
    else $error("rx_final without rx_valid");

  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.command_rejected |-> out_word_o.engine_busy)
    else $error("command rejected while idle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.transfer_done |->
      !out_word_o.engine_busy && !out_word_o.scl_pull_low && !out_word_o.sda_pull_low)
    else $error("stop finished with bus still driven or busy");

  // a sampled bit closes the SCL high phase
  a_sample_scl_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.rx_valid || out_word_o.no_ack) |->
      out_word_o.scl_pull_low && out_word_o.engine_busy)
    else $error("sample reported without SCL pulled low");

endmodule

bind i2c_master_register_access_top i2cm_checker u_i2cm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire

>>> sim/tb_i2c_master_register_access_top.sv
// Self-checking testbench for the I2C register-access master: tick/command words in, line state out.
`timescale 1ns / 1ps

module tb_i2c_master_register_access_top;

  localparam int unsigned CLK_PERIOD      = 10;
  localparam int unsigned RESET_CYCLES    = 12;
  localparam int unsigned CYCLE_LIMIT     = 500000;
  localparam int unsigned ITEMS_PER_PHASE = 144;
  localparam int unsigned TIMING_PHASES   = 8;
  // Padding after a drain, before the timing registers are touched.
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned TAIL_CYCLES     = 10;
  // Receiver back-pressure: one long hold after this many words.
  localparam int unsigned HOLD_AT         = 500;
  localparam int unsigned HOLD_CYCLES     = 150;

  // Kind 3 has no meaning; the block must ignore it.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [i2cm_pkg::PADDR_W-1:0] ADDR_SETUP = {i2cm_pkg::REG_SETUP, 2'b00};
  localparam logic [i2cm_pkg::PADDR_W-1:0] ADDR_HALF  = {i2cm_pkg::REG_HALF, 2'b00};

  // DUT connections; every input has a known value from time zero.
  logic                             clk_i       = 1'b0;
  logic                             rst_ni      = 1'b0;
  logic                             in_valid_i  = 1'b0;
  logic                             in_stall_o;
  i2cm_pkg::i2cm_in_t               in_word_i   = '0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  i2cm_pkg::i2cm_out_t              out_word_o;
  logic                             psel        = 1'b0;
  logic                             penable     = 1'b0;
  logic                             pwrite      = 1'b0;
  logic [i2cm_pkg::PADDR_W-1:0]     paddr       = '0;
  logic [31:0]                      pwdata      = '0;
  logic [31:0]                      prdata;
  logic                             pready;

  i2c_master_register_access_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Sequencer model. Mirrors the block one word at a time: timing registers,
  // phase, tick counter, bit/sub-step position, byte index, shifter, the
  // latched command and the two open-drain pull bits.
  // ---------------------------------------------------------------------------
  logic [7:0]        cfg_setup;
  logic [7:0]        cfg_half;
  i2cm_pkg::phase_e  m_phase;
  int unsigned       m_ticks;
  logic [3:0]        m_bit;
  int unsigned       m_bytes;
  logic [7:0]        m_shift;
  logic [6:0]        m_dev;
  logic [7:0]        m_reg;
  logic [7:0]        m_val;
  logic [7:0]        m_count;
  logic              m_rd;
  logic              m_scl;
  logic              m_sda;

  task automatic reset_model();
    cfg_setup = i2cm_pkg::SETUP_RST;
    cfg_half  = i2cm_pkg::HALF_RST;
    m_phase   = i2cm_pkg::PH_IDLE;
    m_ticks   = 0;
    m_bit     = '0;
    m_bytes   = 0;
    m_shift   = '0;
    m_dev     = '0;
    m_reg     = '0;
    m_val     = '0;
    m_count   = '0;
    m_rd      = 1'b0;
    m_scl     = 1'b0;
    m_sda     = 1'b0;
  endtask

  // Byte 0: write address, 1: register, 2: read address or data value.
  task automatic load_tx_byte(input int unsigned idx);
    logic [7:0] addr_byte;
    addr_byte = {m_dev, 1'b0};
    m_bytes = idx;
    if (idx == 0)      m_shift = addr_byte;
    else if (idx == 1) m_shift = m_reg;
    else               m_shift = m_rd ? (addr_byte | 8'h01) : m_val;
    m_bit   = '0;
    m_ticks = 0;
    m_phase = i2cm_pkg::PH_TX;
  endtask

  task automatic enter_stop();
    m_phase = i2cm_pkg::PH_STOP;
    m_bit   = '0;
    m_ticks = 0;
  endtask

  function automatic logic last_rx_byte();
    return (m_bytes + 1) >= m_count;
  endfunction

  task automatic sequencer_step(input i2cm_pkg::i2cm_in_t w, output i2cm_pkg::i2cm_out_t r);
    int unsigned h;
    int unsigned s;
    r = '0;
    if (w.kind == i2cm_pkg::KIND_WRITE || w.kind == i2cm_pkg::KIND_READ) begin
      if (m_phase != i2cm_pkg::PH_IDLE) begin
        r.command_rejected = 1'b1;
      end else begin
        m_dev   = w.device_address;
        m_reg   = w.register_address;
        m_val   = w.write_value;
        m_count = (w.read_count == 8'd0) ? 8'd1 : w.read_count;
        m_rd    = (w.kind == i2cm_pkg::KIND_READ);
        m_ticks = 0;
        m_bit   = '0;
        m_bytes = 0;
        m_phase = i2cm_pkg::PH_WAIT;
      end
    end else if (w.kind == i2cm_pkg::KIND_TICK) begin
      // Clamp timing: half at least 2, setup in 1..half-1.
      h = (cfg_half < i2cm_pkg::HALF_MIN) ? i2cm_pkg::HALF_MIN : cfg_half;
      s = (cfg_setup == 8'd0) ? 1 : cfg_setup;
      if (s >= h) s = h - 1;
      case (m_phase)
        i2cm_pkg::PH_WAIT: begin
          if (w.sda_in && w.scl_in) begin
            m_phase = i2cm_pkg::PH_START;
            m_sda   = 1'b1;
            m_scl   = 1'b0;
            m_ticks = 0;
          end
        end
        i2cm_pkg::PH_START: begin
          m_ticks++;
          if (m_ticks >= s) begin
            m_scl = 1'b1;
            load_tx_byte(0);
          end
        end
        i2cm_pkg::PH_TX, i2cm_pkg::PH_RX: begin
          m_ticks++;
          if (m_scl) begin
            // SCL low phase: SDA moves after setup, SCL released after half.
            if (m_ticks >= s) begin
              if (m_phase == i2cm_pkg::PH_TX)
                m_sda = (m_bit < i2cm_pkg::BITS_PER_BYTE) ? ~m_shift[7] : 1'b0;
              else
                m_sda = (m_bit < i2cm_pkg::BITS_PER_BYTE) ? 1'b0 : ~last_rx_byte();
            end
            if (m_ticks >= h) begin
              m_scl   = 1'b0;
              m_ticks = 0;
            end
          end else if (m_ticks >= h) begin
            // End of SCL high phase: sample SDA, pull SCL low again.
            m_scl   = 1'b1;
            m_ticks = 0;
            if (m_phase == i2cm_pkg::PH_TX) begin
              if (m_bit < i2cm_pkg::BITS_PER_BYTE) begin
                m_shift = m_shift << 1;
                m_bit++;
              end else begin
                r.no_ack = w.sda_in;
                if (m_bytes == 0) begin
                  load_tx_byte(1);
                end else if (m_bytes == 1) begin
                  if (m_rd) begin
                    m_phase = i2cm_pkg::PH_RESTART;
                    m_bit   = '0;
                  end else begin
                    load_tx_byte(2);
                  end
                end else if (m_rd) begin
                  m_phase = i2cm_pkg::PH_RX;
                  m_bytes = 0;
                  m_bit   = '0;
                  m_shift = '0;
                end else begin
                  enter_stop();
                end
              end
            end else begin
              if (m_bit < i2cm_pkg::BITS_PER_BYTE) begin
                m_shift = {m_shift[6:0], w.sda_in};
                m_bit++;
                if (m_bit == i2cm_pkg::BITS_PER_BYTE) begin
                  r.rx_valid = 1'b1;
                  r.rx_data  = m_shift;
                  r.rx_final = last_rx_byte();
                end
              end else if (last_rx_byte()) begin
                enter_stop();
              end else begin
                m_bytes = (m_bytes + 1) & 8'hFF;
                m_bit   = '0;
                m_shift = '0;
              end
            end
          end
        end
        i2cm_pkg::PH_RESTART: begin
          m_ticks++;
          if (m_bit == 4'd0) begin
            m_sda = 1'b0;
            if (m_ticks >= h) begin
              m_scl   = 1'b0;
              m_ticks = 0;
              m_bit   = i2cm_pkg::SUB_STEP_1;
            end
          end else if (m_bit == i2cm_pkg::SUB_STEP_1) begin
            if (m_ticks >= s) begin
              m_sda   = 1'b1;
              m_ticks = 0;
              m_bit   = i2cm_pkg::SUB_STEP_2;
            end
          end else if (m_ticks >= s) begin
            m_scl = 1'b1;
            load_tx_byte(2);
          end
        end
        i2cm_pkg::PH_STOP: begin
          m_ticks++;
          if (m_bit == 4'd0) begin
            if (m_ticks >= s) m_sda = 1'b1;
            if (m_ticks >= h) begin
              m_scl   = 1'b0;
              m_ticks = 0;
              m_bit   = i2cm_pkg::SUB_STEP_1;
            end
          end else if (m_ticks >= s) begin
            m_sda             = 1'b0;
            r.transfer_done   = 1'b1;
            m_phase           = i2cm_pkg::PH_IDLE;
            m_ticks           = 0;
            m_bit             = '0;
            m_bytes           = 0;
          end
        end
        default: ;
      endcase
      m_ticks &= 8'hFF;
    end
    r.scl_pull_low = m_scl;
    r.sda_pull_low = m_sda;
    r.engine_busy  = (m_phase != i2cm_pkg::PH_IDLE);
  endtask

  // ---------------------------------------------------------------------------
  // Shared bookkeeping
  // ---------------------------------------------------------------------------
  i2cm_pkg::i2cm_out_t predicted_lines[$];   // one entry per accepted word, oldest first
  int unsigned fail_count   = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count  = 0;
  bit          calm         = 1'b0;  // no idling on either side while set

  // Mostly no gap, sometimes a short one, rarely a long stretch.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hard stop if the run hangs anywhere.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[i2c_master_register_access_top] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random stall, one long hold, field-by-field compare.
  // ---------------------------------------------------------------------------
  task automatic check_result(input i2cm_pkg::i2cm_out_t got);
    i2cm_pkg::i2cm_out_t want;
    bit                  bad;
    results_seen++;
    if (predicted_lines.size() == 0) begin
      $error("result word with nothing expected: %h", got);
      fail_count++;
      return;
    end
    want = predicted_lines.pop_front();
    bad  = 1'b0;
    if (got.scl_pull_low !== want.scl_pull_low) begin
      $error("scl_pull_low expected %0d got %0d", want.scl_pull_low, got.scl_pull_low);
      bad = 1'b1;
    end
    if (got.sda_pull_low !== want.sda_pull_low) begin
      $error("sda_pull_low expected %0d got %0d", want.sda_pull_low, got.sda_pull_low);
      bad = 1'b1;
    end
    if (got.rx_data !== want.rx_data) begin
      $error("rx_data expected %02h got %02h", want.rx_data, got.rx_data);
      bad = 1'b1;
    end
    if (got.rx_valid !== want.rx_valid) begin
      $error("rx_valid expected %0d got %0d", want.rx_valid, got.rx_valid);
      bad = 1'b1;
    end
    if (got.rx_final !== want.rx_final) begin
      $error("rx_final expected %0d got %0d", want.rx_final, got.rx_final);
      bad = 1'b1;
    end
    if (got.no_ack !== want.no_ack) begin
      $error("no_ack expected %0d got %0d", want.no_ack, got.no_ack);
      bad = 1'b1;
    end
    if (got.engine_busy !== want.engine_busy) begin
      $error("engine_busy expected %0d got %0d", want.engine_busy, got.engine_busy);
      bad = 1'b1;
    end
    if (got.transfer_done !== want.transfer_done) begin
      $error("transfer_done expected %0d got %0d", want.transfer_done, got.transfer_done);
      bad = 1'b1;
    end
    if (got.command_rejected !== want.command_rejected) begin
      $error("command_rejected expected %0d got %0d",
             want.command_rejected, got.command_rejected);
      bad = 1'b1;
    end
    if (bad) fail_count++;
  endtask

  int unsigned stall_left = 0;
  bit          held_once  = 1'b0;

  // Outputs are sampled right after the edge, i.e. the values the edge saw.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) check_result(out_word_o);
      // Long hold while the sender keeps offering: the input side must back up.
      if (!held_once && results_seen >= HOLD_AT) begin
        held_once  = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one word after an optional gap; returns once the edge accepted it.
  // Valid is left high so a back-to-back word needs no second assignment.
  task automatic send_word(input i2cm_pkg::i2cm_in_t w, input bit typed,
                           input i2cm_pkg::i2cm_out_t typed_want);
    int unsigned         gap;
    i2cm_pkg::i2cm_out_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sequencer_step(w, pred);
    predicted_lines.push_back(typed ? typed_want : pred);
  endtask

  // Stop offering and let every outstanding word come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (predicted_lines.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access; lands on the edge with pready high.
  task automatic apb_write(input logic [i2cm_pkg::PADDR_W-1:0] addr, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {24'($urandom), value};   // upper bits are don't-care
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_SETUP) cfg_setup = value;
    else                    cfg_half  = value;
    @(posedge clk_i);
  endtask

  task automatic apb_check(input logic [i2cm_pkg::PADDR_W-1:0] addr, input logic [7:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[7:0] !== want) begin
      $error("prdata at %0h expected %02h got %02h", addr, want, prdata[7:0]);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random word shaped by where the sequencer is, so most traffic is real
  // transactions: commands when idle, bus-free ticks while waiting, then
  // ticks with SCL high and random SDA for ACK and data bits. The rest is
  // noise: unused kind, commands into a busy engine, odd line levels.
  function automatic i2cm_pkg::i2cm_in_t make_word();
    i2cm_pkg::i2cm_in_t w;
    int unsigned        roll;
    w.kind             = i2cm_pkg::KIND_TICK;
    w.device_address   = 7'($urandom);
    w.register_address = 8'($urandom);
    w.write_value      = 8'($urandom);
    w.read_count       = 8'($urandom);
    w.sda_in           = 1'($urandom);
    w.scl_in           = 1'($urandom);
    roll = $urandom_range(0, 99);
    if (m_phase == i2cm_pkg::PH_IDLE) begin
      if (roll < 70) begin
        w.kind       = (roll < 35) ? i2cm_pkg::KIND_WRITE : i2cm_pkg::KIND_READ;
        // Short reads keep transactions finishing; zero stands for one.
        w.read_count = ($urandom_range(0, 9) < 2) ? 8'd0 : 8'($urandom_range(1, 3));
      end else if (roll < 80) begin
        w.kind = KIND_UNUSED;
      end
    end else if (m_phase == i2cm_pkg::PH_WAIT) begin
      if (roll < 75) begin
        w.sda_in = 1'b1;
        w.scl_in = 1'b1;
      end else if (roll < 85) begin
        w.kind = KIND_UNUSED;
      end else if (roll < 92) begin
        w.kind = $urandom_range(0, 1) ? i2cm_pkg::KIND_WRITE : i2cm_pkg::KIND_READ;
      end
    end else begin
      if (roll < 4) begin
        w.kind = $urandom_range(0, 1) ? i2cm_pkg::KIND_WRITE : i2cm_pkg::KIND_READ;
      end else if (roll < 7) begin
        w.kind = KIND_UNUSED;
      end else if (roll < 90) begin
        w.scl_in = 1'b1;
      end
    end
    return w;
  endfunction

  // Timing plan per random phase: limits, out-of-range values, random picks,
  // and the reset values last.
  function automatic i2cm_pkg::i2cm_timing_t timing_plan(input int unsigned idx);
    i2cm_pkg::i2cm_timing_t t;
    case (idx)
      0:       t = '{setup: 8'd1,   half: 8'd2};     // smallest legal
      1:       t = '{setup: 8'd0,   half: 8'd0};     // both below range
      3:       t = '{setup: 8'd255, half: 8'd255};   // largest
      4:       t = '{setup: 8'd200, half: 8'd3};     // setup saturates
      5:       t = '{setup: 8'd3,   half: 8'd1};     // half below 2
      7:       t = '{setup: i2cm_pkg::SETUP_RST, half: i2cm_pkg::HALF_RST};
      default: t = '{setup: 8'($urandom_range(0, 6)), half: 8'($urandom_range(0, 6))};
    endcase
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef struct {
    i2cm_pkg::i2cm_in_t  w;
    bit                  typed;
    i2cm_pkg::i2cm_out_t want;
  } directed_row_t;

  directed_row_t directed_rows[$];

  function automatic i2cm_pkg::i2cm_in_t word_of(input logic [1:0] kind, input logic [6:0] dev,
                                                 input logic [7:0] rg, input logic [7:0] val,
                                                 input logic [7:0] cnt, input logic sda,
                                                 input logic scl);
    i2cm_pkg::i2cm_in_t w;
    w.kind             = kind;
    w.device_address   = dev;
    w.register_address = rg;
    w.write_value      = val;
    w.read_count       = cnt;
    w.sda_in           = sda;
    w.scl_in           = scl;
    return w;
  endfunction

  function automatic i2cm_pkg::i2cm_out_t lines_of(input logic scl, input logic sda,
                                                   input logic busy, input logic rej);
    i2cm_pkg::i2cm_out_t r;
    r                  = '0;
    r.scl_pull_low     = scl;
    r.sda_pull_low     = sda;
    r.engine_busy      = busy;
    r.command_rejected = rej;
    return r;
  endfunction

  task automatic add_row(input i2cm_pkg::i2cm_in_t w, input bit typed,
                         input i2cm_pkg::i2cm_out_t want);
    directed_row_t row;
    row.w     = w;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  task automatic build_directed();
    // Idle tick with both lines low: nothing moves.
    add_row(word_of(i2cm_pkg::KIND_TICK, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0), 1'b1,
            lines_of(1'b0, 1'b0, 1'b0, 1'b0));
    // Unused kind with every field high: ignored.
    add_row(word_of(KIND_UNUSED, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1), 1'b1,
            lines_of(1'b0, 1'b0, 1'b0, 1'b0));
    // Read with zero count (acts as one), top address; line inputs ignored.
    add_row(word_of(i2cm_pkg::KIND_READ, 7'h7F, 8'hFF, 8'hFF, 8'h00, 1'b1, 1'b1), 1'b1,
            lines_of(1'b0, 1'b0, 1'b1, 1'b0));
    // Commands into the busy engine are rejected, latched fields untouched.
    add_row(word_of(i2cm_pkg::KIND_WRITE, 7'h00, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b0), 1'b1,
            lines_of(1'b0, 1'b0, 1'b1, 1'b1));
    add_row(word_of(i2cm_pkg::KIND_READ, 7'h55, 8'hAA, 8'h55, 8'hAA, 1'b1, 1'b0), 1'b1,
            lines_of(1'b0, 1'b0, 1'b1, 1'b1));
    // Bus not free yet: only one line high.
    add_row(word_of(i2cm_pkg::KIND_TICK, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1), 1'b1,
            lines_of(1'b0, 1'b0, 1'b1, 1'b0));
    add_row(word_of(i2cm_pkg::KIND_TICK, 7'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0), 1'b1,
            lines_of(1'b0, 1'b0, 1'b1, 1'b0));
    // Bus free: START pulls SDA low.
    add_row(word_of(i2cm_pkg::KIND_TICK, 7'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1), 1'b1,
            lines_of(1'b0, 1'b1, 1'b1, 1'b0));
    // Unused kind mid-transfer still reports the drives.
    add_row(word_of(KIND_UNUSED, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0), 1'b1,
            lines_of(1'b0, 1'b1, 1'b1, 1'b0));
    // Run into the first address bits; checked by the model.
    for (int i = 0; i < 14; i++)
      add_row(word_of(i2cm_pkg::KIND_TICK, 7'h2A, 8'h00, 8'h00, 8'h00, 1'(i), 1'b1), 1'b0,
              '0);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    i2cm_pkg::i2cm_timing_t t;
    reset_model();
    build_directed();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values of the timing registers.
    apb_check(ADDR_SETUP, i2cm_pkg::SETUP_RST);
    apb_check(ADDR_HALF, i2cm_pkg::HALF_RST);

    foreach (directed_rows[i])
      send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].want);

    // Random phases; the timing change lands while a transfer may be in
    // flight, which the block must follow at once.
    for (int p = 0; p < TIMING_PHASES; p++) begin
      drain();
      t = timing_plan(p);
      apb_write(ADDR_SETUP, t.setup);
      apb_write(ADDR_HALF, t.half);
      apb_check(ADDR_SETUP, t.setup);
      apb_check(ADDR_HALF, t.half);
      calm = (p == 2 || p == 5);
      repeat (ITEMS_PER_PHASE) send_word(make_word(), 1'b0, '0);
    end
    calm = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[i2c_master_register_access_top] OK");
    end else begin
      $display("[i2c_master_register_access_top] ERROR");
    end
    $finish;
  end

endmodule
